// ===== src/sidac_pkg.sv =====
// ----------------------------------------------------------------------------
// sidac_pkg
// Shared types and constants for the signed integer to decimal ASCII
// converter.
// ----------------------------------------------------------------------------
package sidac_pkg;

    // Width of one packed BCD digit.
    localparam int BCD_DIGIT_W = 4;

    // ASCII codes used in the text.
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Handover from the converter to the character emitter.
    typedef struct packed {
        logic valid;
        logic negative;
    } hand_t;

endpackage

// ===== src/sidac_conv.sv =====
// ----------------------------------------------------------------------------
// sidac_conv
// Takes one signed value, forms its magnitude and turns it into packed BCD
// by shift-and-add-3, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module sidac_conv #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic signed [VALUE_WIDTH-1:0]                value,
    output sidac_pkg::hand_t                             hand,
    input  logic                                         hand_ready,
    output logic [NUM_DIGITS*sidac_pkg::BCD_DIGIT_W-1:0] bcd
);
    import sidac_pkg::*;

    localparam int BCD_W     = NUM_DIGITS * BCD_DIGIT_W;
    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_DONE  = 3'b100
    } conv_state_t;

    conv_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [VALUE_WIDTH-1:0] raw;
    logic [BCD_W-1:0]       bcd_adj;

    assign raw = value;

    // Add 3 to every digit of 5 or more before the next shift.
    always_comb
    begin
        logic [BCD_DIGIT_W-1:0] digit;
        digit = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit = bcd_reg[BCD_DIGIT_W*i +: BCD_DIGIT_W];
            bcd_adj[BCD_DIGIT_W*i +: BCD_DIGIT_W] =
                (digit >= BCD_DIGIT_W'(5)) ? digit + BCD_DIGIT_W'(3) : digit;
        end
    end

    // Sequencer: accept, shift the magnitude in, hand the digits over.
    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next     = raw[VALUE_WIDTH-1];
                    mag_next     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                    state_next   = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (hand_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign hand.valid    = (state_reg == ST_DONE);
    assign hand.negative = neg_reg;
    assign bcd           = bcd_reg;

    // The shift phase always has bits left to take.
    a_shift_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (bit_cnt_reg != '0))
        else $error("shift phase with empty bit counter");

    // A new transaction is taken only in the idle state.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SHIFT))
        else $error("accepted transaction did not start the shift phase");

    // Leaving the handover state needs the emitter's ready.
    a_hand_done: assert property (@(posedge clk) disable iff (!rst_n)
        (hand.valid && !hand_ready) |=> (state_reg == ST_DONE))
        else $error("handover dropped without ready");

endmodule

// ===== src/sidac_emit.sv =====
// ----------------------------------------------------------------------------
// sidac_emit
// Shifts BCD digits out one per cycle unless the output stalls, skips leading
// zeros, puts a minus sign first for negatives and drives the output register.
// ----------------------------------------------------------------------------
module sidac_emit #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  sidac_pkg::hand_t                             hand,
    output logic                                         hand_ready,
    input  logic [NUM_DIGITS*sidac_pkg::BCD_DIGIT_W-1:0] bcd,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic [7:0]                                   char_code,
    output logic                                         last_char
);
    import sidac_pkg::*;

    localparam int BCD_W = NUM_DIGITS * BCD_DIGIT_W;
    localparam int CNT_W = $clog2(NUM_DIGITS + 1);

    logic                   busy_reg, busy_next;
    logic                   neg_pending_reg, neg_pending_next;
    logic                   started_reg, started_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   slot_free;
    logic [BCD_DIGIT_W-1:0] top_digit;

    assign slot_free = !out_valid_reg || !out_stall;
    assign top_digit = bcd_reg[BCD_W-1 -: BCD_DIGIT_W];

    // One character or one skipped leading zero per cycle, when the slot is free.
    always_comb
    begin
        busy_next        = busy_reg;
        neg_pending_next = neg_pending_reg;
        started_next     = started_reg;
        bcd_next         = bcd_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        char_next        = char_reg;
        last_next        = last_reg;
        if (busy_reg)
        begin
            if (slot_free)
            begin
                if (neg_pending_reg)
                begin
                    out_valid_next   = 1'b1;
                    char_next        = CHAR_MINUS;
                    last_next        = 1'b0;
                    neg_pending_next = 1'b0;
                end
                else if (!started_reg && (top_digit == '0) && (cnt_reg > CNT_W'(1)))
                begin
                    bcd_next = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {{(8-BCD_DIGIT_W){1'b0}}, top_digit};
                    last_next      = (cnt_reg == CNT_W'(1));
                    bcd_next       = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                    cnt_next       = cnt_reg - CNT_W'(1);
                    started_next   = 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
        else if (hand.valid)
        begin
            busy_next        = 1'b1;
            neg_pending_next = hand.negative;
            started_next     = 1'b0;
            bcd_next         = bcd;
            cnt_next         = CNT_W'(NUM_DIGITS);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            neg_pending_reg <= 1'b0;
            started_reg     <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            neg_pending_reg <= neg_pending_next;
            started_reg     <= started_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign hand_ready = !busy_reg;
    assign out_valid  = out_valid_reg;
    assign char_code  = char_reg;
    assign last_char  = last_reg;

    // A busy emitter always has digits left.
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("emitter busy with no digits left");

    // The sign is never the final character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == CHAR_MINUS)) |-> !last_reg)
        else $error("minus sign flagged as last character");

    // The sign goes out before any digit.
    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        neg_pending_reg |-> !started_reg)
        else $error("sign pending after digits started");

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Flow: the converter forms the magnitude and shifts it into BCD one bit per
//   cycle, and takes the next number once the emitter has taken the digits,
//   while the previous text may still be going out. Characters leave at one
//   per cycle while the output is not stalled; each leading zero digit is
//   skipped in a slot of its own, after the minus sign for a negative value.
// Reset: rst_n clears the sequencers and output valid; no data is kept.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    char_code,
    output logic                          last_char
);
    import sidac_pkg::*;

    // Decimal digits for a VALUE_WIDTH-bit magnitude (1233/4096 ~ log10 2).
    localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;

    hand_t                             hand;
    logic                              hand_ready;
    logic [NUM_DIGITS*BCD_DIGIT_W-1:0] bcd;

    // Binary magnitude to BCD conversion.
    sidac_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .hand       (hand),
        .hand_ready (hand_ready),
        .bcd        (bcd)
    );

    // Character emission.
    sidac_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .hand       (hand),
        .hand_ready (hand_ready),
        .bcd        (bcd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule

// ===== test/tb_signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Sends signed integers into the converter and checks every ASCII character
// that comes back, in order, against a predicted text. Covers the extremes,
// zero, every digit count with both signs, random idling on both sides, a
// long receiver hold-off that backs up the input, and a full drain pause.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

    import sidac_pkg::*;

    localparam int VALUE_WIDTH   = 32;
    localparam int IDLE_PERCENT  = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 64;
    localparam int WATCHDOG_MAX  = 5000;

    // One character of expected text.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [7:0]                    char_code;
    logic                          last_char;

    text_char_t pending_chars[$];
    int         error_count = 0;
    bit         tx_idle_on = 1'b0;
    bit         rx_idle_on = 1'b0;
    bit         rx_hold_req = 1'b0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .char_code(char_code),
        .last_char(last_char)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Work out the decimal text of one number and queue its characters.
    // The magnitude is taken as unsigned, so the most negative value is exact.
    function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digits[0:23];
        int                     nd;
        int                     k;
        text_char_t             c;
        mag = v;
        nd = 0;
        if (v[VALUE_WIDTH-1])
        begin
            mag = ~mag + 1'b1;
        end
        do
        begin
            digits[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end
        while (mag != 0);
        if (v[VALUE_WIDTH-1])
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (k = nd - 1; k >= 0; k--)
        begin
            c.code = CHAR_ZERO + digits[k];
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // Random number with a random digit count and sign.
    function automatic logic signed [VALUE_WIDTH-1:0] random_number();
        int                            ndig;
        int unsigned                   top;
        logic signed [VALUE_WIDTH-1:0] v;
        ndig = $urandom_range(1, 10);
        if (ndig == 10)
        begin
            v = $urandom;
        end
        else
        begin
            top = 10 ** ndig - 1;
            v = $urandom_range(0, top);
            if ($urandom_range(0, 1))
            begin
                v = -v;
            end
        end
        return v;
    endfunction

    // Offer one number and hold it until the converter takes the transaction.
    task automatic send_number(input logic signed [VALUE_WIDTH-1:0] v);
        if (tx_idle_on && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_text(v);
    endtask

    // Drop valid and wait until every expected character has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Extremes, zero, sign boundaries and digit-count boundaries.
    task automatic test_directed();
        logic signed [VALUE_WIDTH-1:0] cases[$];
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        cases = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                  32'sd99, 32'sd100, -32'sd100, 32'sd999999999, -32'sd999999999,
                  32'sd1000000000, -32'sd1000000000, 32'sd2147483647,
                  -32'sd2147483647, 32'sh80000000, 32'sd1234567890,
                  32'sh55555555, 32'shAAAAAAAA, 32'sd5};
        foreach (cases[i])
        begin
            send_number(cases[i]);
        end
        wait_for_drain();
    endtask

    // Random numbers with idling on both sides.
    task automatic test_random_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (90) send_number(random_number());
    endtask

    // A long stretch at full rate with no idling at all.
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (40) send_number(random_number());
    endtask

    // The receiver holds off while the sender keeps offering numbers.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_req = 1'b1;
        repeat (25) send_number(random_number());
        rx_idle_on = 1'b1;
    endtask

    // The sender pauses mid-stream until all text has arrived.
    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (15) send_number(random_number());
        wait_for_drain();
        repeat (20) send_number(random_number());
    endtask

    // Receiver side: random stall, or a counted hold-off when requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (rx_idle_on)
            begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted character with the oldest expected one.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character transaction: char_code=%0d last_char=%0b",
                       char_code, last_char);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code: expected %0d, actual %0d", want.code, char_code);
                    error_count++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %0b, actual %0b", want.last, last_char);
                    error_count++;
                end
            end
        end
    end

    // End the run when no transaction happens for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_MAX)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_idle();
        test_full_rate();
        test_backpressure();
        test_drain_pause();
        wait_for_drain();
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
